// ===== design/isoep_pkg.sv =====
// ----------------------------------------------------------------------------
// isoep_pkg
// Types, constants and tables shared by the ISO 8601 to epoch seconds block.
// ----------------------------------------------------------------------------
package isoep_pkg;

   typedef enum logic [2:0] {
      PH_FIXED,
      PH_TAIL,
      PH_FRAC,
      PH_OFFH,
      PH_OFFM,
      PH_DONE
   } phase_type;

   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int FIXED_LEN    = 19;
   localparam int FIFO_DEPTH   = 4;
   localparam int EPOCH_YEAR   = 1970;
   localparam int LEAP_BASE    = 1969;
   localparam int CENT_BASE    = 1901;
   localparam int QUAD_BASE    = 1601;
   localparam int SEC_PER_DAY  = 86400;
   localparam int SEC_PER_HOUR = 3600;
   localparam int SEC_PER_MIN  = 60;
   localparam int DAYS_PER_YR  = 365;
   // floor(m / 100) == (m * RECIP_100) >> RECIP_SHIFT for m below 43690
   localparam int RECIP_100    = 5243;
   localparam int RECIP_SHIFT  = 19;

   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        off_neg;
      logic [6:0]  off_hour;
      logic [6:0]  off_minute;
   } rec_type;

   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] days;
      unique case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== design/isoep_front.sv =====
// ----------------------------------------------------------------------------
// isoep_front
// Character parser: walks the fixed fields, fraction and offset, and on the
// last character emits one parsed record with its ok flag.
// ----------------------------------------------------------------------------
module isoep_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         char_code,
   input  logic               last,
   output logic               push,
   output isoep_pkg::rec_type push_data
);

   localparam logic [4:0] POS_END = 5'(isoep_pkg::FIXED_LEN - 1);

   isoep_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        off_neg_ff, off_neg_in;
   logic [6:0]  off_hour_ff, off_hour_in;
   logic [6:0]  off_minute_ff, off_minute_in;
   logic [1:0]  off_cnt_ff, off_cnt_in;
   logic        ferr_ff, ferr_in;

   logic       is_digit;
   logic       is_sign;
   logic [3:0] digit;

   assign is_digit = (char_code >= isoep_pkg::CH_ZERO) && (char_code <= isoep_pkg::CH_NINE);
   assign is_sign  = (char_code == isoep_pkg::CH_PLUS) || (char_code == isoep_pkg::CH_DASH);
   assign digit    = char_code[3:0];

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      second_in     = second_ff;
      off_neg_in    = off_neg_ff;
      off_hour_in   = off_hour_ff;
      off_minute_in = off_minute_ff;
      off_cnt_in    = off_cnt_ff;
      ferr_in       = ferr_ff;
      unique case (phase_ff)
         isoep_pkg::PH_FIXED: begin
            priority if (pos_ff == 5'd4 || pos_ff == 5'd7) begin
               if (char_code != isoep_pkg::CH_DASH) ferr_in = 1'b1;
            end else if (pos_ff == 5'd10) begin
               if (char_code != isoep_pkg::CH_T) ferr_in = 1'b1;
            end else if (pos_ff == 5'd13 || pos_ff == 5'd16) begin
               if (char_code != isoep_pkg::CH_COLON) ferr_in = 1'b1;
            end else if (!is_digit) begin
               ferr_in = 1'b1;
            end else if (pos_ff < 5'd4) begin
               year_in = year_ff * 14'd10 + 14'(digit);
            end else if (pos_ff < 5'd7) begin
               month_in = month_ff * 7'd10 + 7'(digit);
            end else if (pos_ff < 5'd10) begin
               day_in = day_ff * 7'd10 + 7'(digit);
            end else if (pos_ff < 5'd13) begin
               hour_in = hour_ff * 7'd10 + 7'(digit);
            end else if (pos_ff < 5'd16) begin
               minute_in = minute_ff * 7'd10 + 7'(digit);
            end else begin
               second_in = second_ff * 7'd10 + 7'(digit);
            end
            pos_in = pos_ff + 5'd1;
            if (pos_ff == POS_END) phase_in = isoep_pkg::PH_TAIL;
         end
         isoep_pkg::PH_TAIL, isoep_pkg::PH_FRAC: begin
            priority if (phase_ff == isoep_pkg::PH_TAIL && char_code == isoep_pkg::CH_DOT) begin
               phase_in = isoep_pkg::PH_FRAC;
            end else if (phase_ff == isoep_pkg::PH_FRAC && is_digit) begin
               phase_in = isoep_pkg::PH_FRAC;
            end else if (is_sign) begin
               off_neg_in = (char_code == isoep_pkg::CH_DASH);
               off_cnt_in = 2'd0;
               phase_in   = isoep_pkg::PH_OFFH;
            end else begin
               phase_in = isoep_pkg::PH_DONE;
            end
         end
         isoep_pkg::PH_OFFH: begin
            priority if (is_digit && off_cnt_ff < 2'd2) begin
               off_hour_in = off_hour_ff * 7'd10 + 7'(digit);
               off_cnt_in  = off_cnt_ff + 2'd1;
            end else if (char_code == isoep_pkg::CH_COLON && off_cnt_ff >= 2'd1) begin
               off_cnt_in = 2'd0;
               phase_in   = isoep_pkg::PH_OFFM;
            end else begin
               phase_in = isoep_pkg::PH_DONE;
            end
         end
         isoep_pkg::PH_OFFM: begin
            if (is_digit && off_cnt_ff < 2'd2) begin
               off_minute_in = off_minute_ff * 7'd10 + 7'(digit);
               off_cnt_in    = off_cnt_ff + 2'd1;
            end else begin
               phase_in = isoep_pkg::PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      push_data.ok = (phase_in != isoep_pkg::PH_FIXED) && !ferr_in
                     && (month_in >= 7'd1) && (month_in <= 7'd12)
                     && (day_in >= 7'd1) && (day_in <= 7'd31);
      push_data.year       = year_in;
      push_data.month      = month_in[3:0];
      push_data.day        = day_in[4:0];
      push_data.hour       = hour_in;
      push_data.minute     = minute_in;
      push_data.second     = second_in;
      push_data.off_neg    = off_neg_in;
      push_data.off_hour   = off_hour_in;
      push_data.off_minute = off_minute_in;
   end

   assign push = accept && last;

   always_ff @(posedge clock) begin
      if (reset || (accept && last)) begin
         phase_ff      <= isoep_pkg::PH_FIXED;
         pos_ff        <= '0;
         year_ff       <= '0;
         month_ff      <= '0;
         day_ff        <= '0;
         hour_ff       <= '0;
         minute_ff     <= '0;
         second_ff     <= '0;
         off_neg_ff    <= 1'b0;
         off_hour_ff   <= '0;
         off_minute_ff <= '0;
         off_cnt_ff    <= '0;
         ferr_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         year_ff       <= year_in;
         month_ff      <= month_in;
         day_ff        <= day_in;
         hour_ff       <= hour_in;
         minute_ff     <= minute_in;
         second_ff     <= second_in;
         off_neg_ff    <= off_neg_in;
         off_hour_ff   <= off_hour_in;
         off_minute_ff <= off_minute_in;
         off_cnt_ff    <= off_cnt_in;
         ferr_ff       <= ferr_in;
      end
   end

endmodule

// ===== design/isoep_fifo.sv =====
// ----------------------------------------------------------------------------
// isoep_fifo
// Small record queue between parser and arithmetic pipeline.
// ----------------------------------------------------------------------------
module isoep_fifo #(
   parameter int DEPTH = isoep_pkg::FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  isoep_pkg::rec_type push_data,
   output logic               full,
   input  logic               pop,
   output isoep_pkg::rec_type pop_data,
   output logic               empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   isoep_pkg::rec_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (!push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== design/isoep_back.sv =====
// ----------------------------------------------------------------------------
// isoep_back
// Three-stage arithmetic pipeline: day count, time of day and offset,
// then days * 86400 plus seconds. The last stage is the output register.
// ----------------------------------------------------------------------------
module isoep_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               rec_avail,
   input  isoep_pkg::rec_type rec,
   output logic               rec_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [38:0]        out_seconds,
   output logic               out_ok
);

   localparam int RS = isoep_pkg::RECIP_SHIFT;

   function automatic logic signed [23:0] apply_sign(input logic neg, input logic [6:0] mag);
      logic signed [23:0] v;
      v = $signed({17'b0, mag});
      return neg ? -v : v;
   endfunction

   function automatic logic [14:0] abs16(input logic signed [15:0] v);
      logic signed [15:0] a;
      a = (v < 0) ? -v : v;
      return a[14:0];
   endfunction

   logic en;

   // stage 1
   logic               v1_ff;
   logic               ok1_ff;
   logic signed [23:0] days_lin_ff, days_lin_in;
   logic signed [23:0] q4_ff, q4_in;
   logic [27:0]        p100_ff, p100_in;
   logic               n100_ff, n100_in;
   logic [27:0]        p400_ff, p400_in;
   logic               n400_ff, n400_in;
   logic [27:0]        py_ff, py_in;
   logic [13:0]        year1_ff;
   logic [8:0]         ydl_ff, ydl_in;
   logic               mgt2_ff;
   logic [18:0]        tod_ff, tod_in;
   logic [18:0]        off_ff, off_in;
   logic               off_neg_ff;

   logic signed [15:0] ys, a_lin, a4, a100, a400;
   logic [14:0]        m4, m100, m400;

   always_comb begin
      ys    = $signed({2'b0, rec.year});
      a_lin = ys - 16'(isoep_pkg::EPOCH_YEAR);
      a4    = ys - 16'(isoep_pkg::LEAP_BASE);
      a100  = ys - 16'(isoep_pkg::CENT_BASE);
      a400  = ys - 16'(isoep_pkg::QUAD_BASE);
      m4    = abs16(a4);
      m100  = abs16(a100);
      m400  = abs16(a400);
      days_lin_in = $signed(24'(a_lin)) * $signed(24'(isoep_pkg::DAYS_PER_YR));
      q4_in   = (a4 < 0) ? -$signed({11'b0, m4[14:2]}) : $signed({11'b0, m4[14:2]});
      p100_in = 28'(m100) * 28'(isoep_pkg::RECIP_100);
      n100_in = (a100 < 0);
      p400_in = 28'(m400[14:2]) * 28'(isoep_pkg::RECIP_100);
      n400_in = (a400 < 0);
      py_in   = 28'(rec.year) * 28'(isoep_pkg::RECIP_100);
      ydl_in  = isoep_pkg::month_start(rec.month) + 9'(rec.day) - 9'd1;
      tod_in  = 19'(rec.hour) * 19'(isoep_pkg::SEC_PER_HOUR)
                + 19'(rec.minute) * 19'(isoep_pkg::SEC_PER_MIN) + 19'(rec.second);
      off_in  = 19'(rec.off_hour) * 19'(isoep_pkg::SEC_PER_HOUR)
                + 19'(rec.off_minute) * 19'(isoep_pkg::SEC_PER_MIN);
   end

   // stage 2
   logic               v2_ff;
   logic               ok2_ff;
   logic signed [23:0] days_ff, days_in;
   logic signed [20:0] secs_ff, secs_in;

   logic [6:0]         q100m, q400m, qy;
   logic               leap;
   logic signed [20:0] tod_s, off_s;

   always_comb begin
      q100m = p100_ff[RS +: 7];
      q400m = p400_ff[RS +: 7];
      qy    = py_ff[RS +: 7];
      leap  = (year1_ff[1:0] == 2'b00)
              && ((14'(qy) * 14'd100 != year1_ff) || (qy[1:0] == 2'b00));
      days_in = days_lin_ff + q4_ff - apply_sign(n100_ff, q100m) + apply_sign(n400_ff, q400m)
                + $signed({15'b0, ydl_ff}) + $signed({23'b0, leap && mgt2_ff});
      tod_s   = $signed({2'b0, tod_ff});
      off_s   = off_neg_ff ? -$signed({2'b0, off_ff}) : $signed({2'b0, off_ff});
      secs_in = tod_s - off_s;
   end

   // stage 3 / output register
   logic               v3_ff;
   logic               ok3_ff;
   logic [38:0]        res_ff, res_in;
   logic signed [40:0] total;

   always_comb begin
      total  = $signed(41'(days_ff)) * $signed(41'(isoep_pkg::SEC_PER_DAY))
               + $signed(41'(secs_ff));
      res_in = ok2_ff ? total[38:0] : '0;
   end

   assign en          = !v3_ff || out_ready;
   assign rec_pop     = en && rec_avail;
   assign out_valid   = v3_ff;
   assign out_seconds = res_ff;
   assign out_ok      = ok3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= rec_avail;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok1_ff      <= rec.ok;
         days_lin_ff <= days_lin_in;
         q4_ff       <= q4_in;
         p100_ff     <= p100_in;
         n100_ff     <= n100_in;
         p400_ff     <= p400_in;
         n400_ff     <= n400_in;
         py_ff       <= py_in;
         year1_ff    <= rec.year;
         ydl_ff      <= ydl_in;
         mgt2_ff     <= (rec.month > 4'd2);
         tod_ff      <= tod_in;
         off_ff      <= off_in;
         off_neg_ff  <= rec.off_neg;
         ok2_ff      <= ok1_ff;
         days_ff     <= days_in;
         secs_ff     <= secs_in;
         ok3_ff      <= ok2_ff;
         res_ff      <= res_in;
      end
   end

endmodule

// ===== design/iso8601_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// iso8601_to_epoch_seconds
// ISO 8601 timestamp text, one character per word, to UTC epoch seconds.
//
//   channel | dir | payload                                  | end of run
//   req_    | in  | tdata[7:0] char_code                     | tlast = last
//   rsp_    | out | tdata[38:0] epoch_seconds, tuser valid_res | one word per run
//
// One character per cycle while the record queue is not full, including one-character runs.
// After the last character is accepted, the record passes through the record queue, then
// the linear-day stage, day-count stage and seconds stage before the result leaves.
// The record queue holds FIFO_DEPTH parsed timestamps; req_tready drops only
// when it is full while rsp_ is stalled.
// Synchronous reset clears parser state, queue and pipeline valids.
// ----------------------------------------------------------------------------
module iso8601_to_epoch_seconds #(
   parameter int FIFO_DEPTH = isoep_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [38:0] epoch_seconds, [39] zero
   output logic        rsp_tuser    // [0] valid_res
);

   logic               accept;
   logic               push;
   isoep_pkg::rec_type push_data;
   logic               full;
   logic               pop;
   isoep_pkg::rec_type pop_data;
   logic               empty;
   logic [38:0]        seconds;

   assign req_tready = !full;
   assign accept     = req_tvalid && !full;

   isoep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_tdata),
      .last      (req_tlast),
      .push      (push),
      .push_data (push_data)
   );

   isoep_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   isoep_back u_back (
      .clock       (clock),
      .reset       (reset),
      .rec_avail   (!empty),
      .rec         (pop_data),
      .rec_pop     (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_seconds (seconds),
      .out_ok      (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, seconds};

endmodule

// ===== design/isoep_checker.sv =====
// ----------------------------------------------------------------------------
// isoep_checker
// Port-level checks for iso8601_to_epoch_seconds, bound to the top level.
// ----------------------------------------------------------------------------
module isoep_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("rejected timestamp carries nonzero seconds");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[39])
      else $error("padding bit set in response");

endmodule

bind iso8601_to_epoch_seconds isoep_checker u_isoep_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for iso8601_to_epoch_seconds. Timestamp text is streamed in one
// character per word, with bursts and gaps. A parser mirror computes the
// expected epoch seconds and valid flag for every run. Each result word is
// checked against it in order, while the receiver stalls randomly and once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic [7:0] code;
      logic       last;
      bit         hold;   // wait for all results before offering this word
   } char_word_type;

   typedef struct {
      logic [38:0] seconds;
      logic        valid;
   } epoch_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   char_word_type    char_words[$];
   logic [7:0]       run_chars[$];
   epoch_result_type epoch_expected[$];
   char_word_type    next_word;

   int words_offered = 0;
   int words_accepted = 0;
   int runs_queued = 0;
   int results_seen = 0;
   int results_valid = 0;
   int mismatches = 0;
   int input_stalls = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_left = 0;
   int mode_left = 0;
   int stall_pct = 0;
   bit long_stall_done = 1'b0;

   // timestamp parser mirror
   isoep_pkg::phase_type ts_phase = isoep_pkg::PH_FIXED;
   int        ts_pos = 0;
   int        ts_year = 0;
   int        ts_month = 0;
   int        ts_day = 0;
   int        ts_hour = 0;
   int        ts_min = 0;
   int        ts_sec = 0;
   bit        ts_off_neg = 1'b0;
   int        ts_off_hour = 0;
   int        ts_off_min = 0;
   int        ts_off_digits = 0;
   bit        ts_bad = 1'b0;

   int month_days [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
   int year_marks [0:9] = '{0, 1, 1600, 1601, 1900, 1969, 1970, 2000, 2100, 9999};

   iso8601_to_epoch_seconds i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_digit(input logic [7:0] c);
      return c >= isoep_pkg::CH_ZERO && c <= isoep_pkg::CH_NINE;
   endfunction

   task automatic push_digits(input int value, input int count);
      logic [7:0] digits[$];
      for (int i = 0; i < count; i++) begin
         digits.push_front(isoep_pkg::CH_ZERO + 8'(value % 10));
         value = value / 10;
      end
      foreach (digits[k]) run_chars.push_back(digits[k]);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) run_chars.push_back(s[i]);
   endtask

   task automatic close_run(input bit hold);
      char_word_type w;
      foreach (run_chars[i]) begin
         w.code = run_chars[i];
         w.last = (i == run_chars.size() - 1);
         w.hold = hold && (i == 0);
         char_words.push_back(w);
      end
      run_chars.delete();
      runs_queued++;
   endtask

   task automatic queue_random_timestamp(input bit hold);
      int kind;
      int tail;
      int n;
      int len;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0:       push_digits($urandom_range(0, 9999), 4);
         1, 2:    push_digits($urandom_range(1900, 2100), 4);
         default: push_digits(year_marks[$urandom_range(0, 9)], 4);
      endcase
      run_chars.push_back(isoep_pkg::CH_DASH);
      push_digits(($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
      run_chars.push_back(isoep_pkg::CH_DASH);
      push_digits(($urandom_range(0, 6) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31), 2);
      run_chars.push_back(isoep_pkg::CH_T);
      push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
      run_chars.push_back(isoep_pkg::CH_COLON);
      push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
      run_chars.push_back(isoep_pkg::CH_COLON);
      push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
      tail = $urandom_range(0, 5);
      if (tail == 1 || tail == 2) begin
         run_chars.push_back(isoep_pkg::CH_DOT);
         push_digits($urandom_range(0, 999999), $urandom_range(0, 6));
      end
      if (tail >= 2 && tail <= 4) begin
         run_chars.push_back($urandom_range(0, 1) ? isoep_pkg::CH_PLUS : isoep_pkg::CH_DASH);
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
         push_digits($urandom_range(0, 999), n);
         if ($urandom_range(0, 1)) begin
            run_chars.push_back(isoep_pkg::CH_COLON);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
            push_digits($urandom_range(0, 999), n);
         end
      end
      if (tail == 5 || $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 3);
         repeat (n) run_chars.push_back(8'($urandom_range(0, 255)));
      end
      if (kind < 10) begin
         run_chars[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
      end else if (kind < 20) begin
         len = $urandom_range(1, 18);
         while (run_chars.size() > len) void'(run_chars.pop_back());
      end
      close_run(hold);
   endtask

   // stimulus, end of run
   initial begin : stimulus
      bit mid_done;
      mid_done = 1'b0;

      queue_text("1970-01-01T00:00:00");                       close_run(1'b0);
      queue_text("9999-12-31T99:99:99.123456789-99:99");       close_run(1'b0);
      queue_text("0000-01-01T00:00:00+99:59");                 close_run(1'b0);
      queue_text("2024-03-01T00:00:00-7:3");                   close_run(1'b0);
      queue_text("2100-03-01T23:59:59+05");                    close_run(1'b0);
      queue_text("2024-01-01T00:00:0");                        close_run(1'b0);
      queue_text("2");                                         close_run(1'b0);
      queue_text("2024-01-01 00:00:00");                       close_run(1'b0);
      queue_text("2024-+1-01T00:00:00");                       close_run(1'b0);
      queue_text("2024-13-01T00:00:00");                       close_run(1'b0);
      queue_text("2024-12-00T00:00:00");                       close_run(1'b0);
      queue_text("2024-06-15T08:30:00Z+01");                   close_run(1'b0);
      queue_text("2024-06-15T08:30:00+123");                   close_run(1'b0);
      queue_text("2024-06-15T08:30:00+:30");                   close_run(1'b0);
      queue_text("2024-06-15T08:30:00-05:301");                close_run(1'b0);
      queue_text("2024-06-15T08:30:00.5");
      run_chars.push_back(8'h00);
      queue_text("+01");                                       close_run(1'b0);
      queue_text("20");
      run_chars.push_back(8'hB2);
      queue_text("4-06-15T08:30:00");                          close_run(1'b0);

      queue_random_timestamp(1'b1);
      while (char_words.size() < 1450) begin
         if (!mid_done && char_words.size() > 900) begin
            mid_done = 1'b1;
            queue_random_timestamp(1'b1);
         end else begin
            queue_random_timestamp(1'b0);
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      while (char_words.size() != 0 || words_accepted != words_offered) @(posedge clock);
      while (epoch_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d timestamps over %0d characters: %0d accepted, %0d rejected.",
               runs_queued, words_accepted, results_valid, results_seen - results_valid);
      $display("Input held off by back-pressure on %0d cycles; %0d mismatches.",
               input_stalls, mismatches);
      if (mismatches == 0) begin
         $display("** iso8601_to_epoch_seconds: PASSED **");
      end else begin
         $display("** iso8601_to_epoch_seconds: FAILED **");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timeout with %0d results still expected.", epoch_expected.size());
      $display("** iso8601_to_epoch_seconds: FAILED **");
      $finish;
   end

   // character driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || words_accepted == words_offered) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (char_words.size() == 0
                      || (char_words[0].hold && epoch_expected.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            next_word = char_words.pop_front();
            req_tdata <= next_word.code;
            req_tlast <= next_word.last;
            req_tvalid <= 1'b1;
            words_offered++;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!long_stall_done && results_seen >= 30) begin
         long_stall_done = 1'b1;
         stall_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               default: stall_pct = 75;
            endcase
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // parser mirror and result check
   always @(posedge clock) begin : monitor
      logic [7:0]       c;
      int               d;
      longint           y;
      longint           days;
      longint           secs;
      longint           off;
      bit               ok;
      epoch_result_type want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (req_tvalid && req_tready) begin
            c = req_tdata;
            d = int'(c) - 48;
            words_accepted++;
            case (ts_phase)
               isoep_pkg::PH_FIXED: begin
                  if (ts_pos == 4 || ts_pos == 7) begin
                     if (c != isoep_pkg::CH_DASH) ts_bad = 1'b1;
                  end else if (ts_pos == 10) begin
                     if (c != isoep_pkg::CH_T) ts_bad = 1'b1;
                  end else if (ts_pos == 13 || ts_pos == 16) begin
                     if (c != isoep_pkg::CH_COLON) ts_bad = 1'b1;
                  end else if (!is_digit(c)) begin
                     ts_bad = 1'b1;
                  end else if (ts_pos < 4) begin
                     ts_year = ts_year * 10 + d;
                  end else if (ts_pos < 7) begin
                     ts_month = ts_month * 10 + d;
                  end else if (ts_pos < 10) begin
                     ts_day = ts_day * 10 + d;
                  end else if (ts_pos < 13) begin
                     ts_hour = ts_hour * 10 + d;
                  end else if (ts_pos < 16) begin
                     ts_min = ts_min * 10 + d;
                  end else begin
                     ts_sec = ts_sec * 10 + d;
                  end
                  ts_pos++;
                  if (ts_pos >= isoep_pkg::FIXED_LEN) ts_phase = isoep_pkg::PH_TAIL;
               end
               isoep_pkg::PH_TAIL, isoep_pkg::PH_FRAC: begin
                  if (!(ts_phase == isoep_pkg::PH_FRAC && is_digit(c))) begin
                     if (ts_phase == isoep_pkg::PH_TAIL && c == isoep_pkg::CH_DOT) begin
                        ts_phase = isoep_pkg::PH_FRAC;
                     end else if (c == isoep_pkg::CH_PLUS || c == isoep_pkg::CH_DASH) begin
                        ts_off_neg = (c == isoep_pkg::CH_DASH);
                        ts_off_digits = 0;
                        ts_phase = isoep_pkg::PH_OFFH;
                     end else begin
                        ts_phase = isoep_pkg::PH_DONE;
                     end
                  end
               end
               isoep_pkg::PH_OFFH: begin
                  if (is_digit(c) && ts_off_digits < 2) begin
                     ts_off_hour = ts_off_hour * 10 + d;
                     ts_off_digits++;
                  end else if (c == isoep_pkg::CH_COLON && ts_off_digits >= 1) begin
                     ts_off_digits = 0;
                     ts_phase = isoep_pkg::PH_OFFM;
                  end else begin
                     ts_phase = isoep_pkg::PH_DONE;
                  end
               end
               isoep_pkg::PH_OFFM: begin
                  if (is_digit(c) && ts_off_digits < 2) begin
                     ts_off_min = ts_off_min * 10 + d;
                     ts_off_digits++;
                  end else begin
                     ts_phase = isoep_pkg::PH_DONE;
                  end
               end
               default: begin
               end
            endcase
            if (req_tlast) begin
               ok = ts_phase != isoep_pkg::PH_FIXED && !ts_bad && ts_month >= 1
                    && ts_month <= 12 && ts_day >= 1 && ts_day <= 31;
               secs = 0;
               if (ok) begin
                  y = ts_year;
                  days = (y - isoep_pkg::EPOCH_YEAR) * isoep_pkg::DAYS_PER_YR
                         + (y - isoep_pkg::LEAP_BASE) / 4
                         - (y - isoep_pkg::CENT_BASE) / 100
                         + (y - isoep_pkg::QUAD_BASE) / 400;
                  days = days + month_days[ts_month - 1] + ts_day - 1;
                  if (((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) && ts_month > 2) days++;
                  secs = days * isoep_pkg::SEC_PER_DAY
                         + longint'(ts_hour) * isoep_pkg::SEC_PER_HOUR
                         + longint'(ts_min) * isoep_pkg::SEC_PER_MIN + ts_sec;
                  off = longint'(ts_off_hour) * isoep_pkg::SEC_PER_HOUR
                        + longint'(ts_off_min) * isoep_pkg::SEC_PER_MIN;
                  secs = ts_off_neg ? secs + off : secs - off;
               end
               want.seconds = secs[38:0];
               want.valid = ok;
               epoch_expected.push_back(want);
               ts_phase = isoep_pkg::PH_FIXED;
               ts_pos = 0;
               ts_year = 0;
               ts_month = 0;
               ts_day = 0;
               ts_hour = 0;
               ts_min = 0;
               ts_sec = 0;
               ts_off_neg = 1'b0;
               ts_off_hour = 0;
               ts_off_min = 0;
               ts_off_digits = 0;
               ts_bad = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser) results_valid++;
            if (epoch_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result word: seconds %0d valid %0b",
                           $signed(rsp_tdata[38:0]), rsp_tuser);
            end else begin
               want = epoch_expected.pop_front();
               if (rsp_tdata[38:0] !== want.seconds || rsp_tuser !== want.valid) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Result %0d: expected seconds %0d valid %0b, got seconds %0d valid %0b",
                              results_seen, $signed(want.seconds), want.valid,
                              $signed(rsp_tdata[38:0]), rsp_tuser);
               end
            end
         end
      end
   end

endmodule

// ===== files.f =====
design/isoep_pkg.sv
design/isoep_front.sv
design/isoep_fifo.sv
design/isoep_back.sv
design/iso8601_to_epoch_seconds.sv
design/isoep_checker.sv
test/tb.sv
